/* src/hre_pkg.sv */
package hre_pkg;

  localparam int COORD_W  = 20;
  localparam int COUNT_W  = 13;
  localparam int COEF_W   = 48;
  localparam int NREGS    = 8;
  localparam int IDX_W    = 3;
  localparam int FRAC     = 8;      // fraction bits of a coordinate
  localparam int MAX_PTS  = 4096;
  localparam int NACC_W   = 56;     // signed projective sums, 16+FRAC fraction bits
  localparam int MAG_W    = 55;
  localparam int REM_W    = 64;
  localparam int DIV_W    = 78;
  localparam int QUO_W    = 22;
  localparam int DIFF_W   = 22;
  localparam int SQ_W     = 46;
  localparam int ROOT_W   = 23;
  localparam int SUM_W    = 33;
  localparam int STEP_W   = 5;

  localparam logic [COORD_W-1:0] DIST_MAX = '1;
  localparam logic [QUO_W-1:0]   PX_LIMIT = QUO_W'(1) << 21;

  localparam logic [COEF_W-1:0] H_RESET [NREGS] = '{
    48'h0001_0000_0000, 48'h0, 48'h0, 48'h0,
    48'h0001_0000_0000, 48'h0, 48'h0, 48'h0
  };

  typedef struct packed {
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] ref_x;
    logic [COORD_W-1:0] ref_y;
    logic               has_match;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] mean_error;
    logic [COUNT_W-1:0] match_count;
    logic               no_match;
  } out_item_t;

endpackage

/* src/homography_reprojection_error.sv */
// Mean homography reprojection error over the keypoints of one frame.
// Input channel in_valid/in_stall/in_data carries one keypoint pair per item;
// output channel out_valid/out_stall/out_data carries one result per frame,
// issued after the item flagged last. Homography coefficients h11..h32 are
// written through cfg_we/cfg_index/cfg_data; the user writes them only
// while the block is idle; the block itself does not enforce this. A matched
// item (up to MAX_PTS per frame) holds in_stall while the block works on it:
// the eight coefficient products, each a low and a high half on one shared
// 25x23 multiplier, two restoring divisions of 22 steps each for the
// projected x and y, two squares on the same multiplier and a 23-step square
// root. A zero projective term or a saturated coordinate shortens this work.
// Unmatched items other than the last are taken without a stall. The last
// item adds a 20-step division for the mean, skipped if there is no match.
// Reset loads the identity homography and clears the sum and count.
// A stalled result holds in the output register; the block keeps taking
// items and only waits if a new frame result is ready before the old one left.
module homography_reprojection_error (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hre_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hre_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [hre_pkg::IDX_W-1:0]        cfg_index,
  input  logic [hre_pkg::COEF_W-1:0]       cfg_data
);

  typedef enum logic [3:0] {
    IDLE, MUL_LO, MUL_HI, CHECK_W, DIV_LOAD, DIV_STEP, SQ_X, SQ_Y,
    SQRT, ACCUM, MEAN_LOAD, EMIT
  } state_t;

  state_t state;

  logic [hre_pkg::COEF_W-1:0]  hreg [hre_pkg::NREGS];
  hre_pkg::in_item_t           item;
  logic [hre_pkg::IDX_W-1:0]   pi;
  logic [1:0]                  row;
  logic [1:0]                  col;
  logic signed [hre_pkg::NACC_W-1:0] nacc [3];
  logic [47:0]                 plo;
  logic                        coord;
  logic                        neg;
  logic                        mean_mode;
  logic [hre_pkg::REM_W-1:0]   rem;
  logic [hre_pkg::DIV_W-1:0]   dvs;
  logic [hre_pkg::QUO_W-1:0]   quo;
  logic [hre_pkg::STEP_W-1:0]  k;
  logic [hre_pkg::DIFF_W-1:0]  dxm;
  logic [hre_pkg::DIFF_W-1:0]  dym;
  logic [hre_pkg::SQ_W-1:0]    ssum;
  logic [hre_pkg::SQ_W-1:0]    sbit;
  logic [hre_pkg::SQ_W-1:0]    sres;
  logic [hre_pkg::COORD_W-1:0] pair_dist;
  logic [hre_pkg::SUM_W-1:0]   error_sum;
  logic [hre_pkg::COUNT_W-1:0] pair_count;

  // Shared multiplier and its operand selection.
  logic signed [24:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [47:0] mul_p;
  logic [hre_pkg::COEF_W-1:0] hsel;
  logic [20:0] vsel;

  always_comb begin
    hsel = hreg[pi];
    case (col)
      2'd0:    vsel = {1'b0, item.cur_x};
      2'd1:    vsel = {1'b0, item.cur_y};
      default: vsel = 21'(1) << hre_pkg::FRAC;
    endcase
    mul_a = $signed({1'b0, hsel[23:0]});
    mul_b = $signed({2'b0, vsel});
    case (state)
      MUL_HI: mul_a = $signed({hsel[47], hsel[47:24]});
      SQ_X, SQRT: begin
        mul_a = $signed({3'b0, dxm});
        mul_b = $signed({1'b0, dxm});
      end
      SQ_Y: begin
        mul_a = $signed({3'b0, dym});
        mul_b = $signed({1'b0, dym});
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Full product of a 48-bit coefficient, floored by 2^16.
  logic signed [71:0] prod_full;
  logic signed [hre_pkg::NACC_W-1:0] prod_q;
  assign prod_full = ($signed({{24{mul_p[47]}}, mul_p}) <<< 24)
                     + $signed({24'b0, plo});
  assign prod_q = hre_pkg::NACC_W'(prod_full >>> 16);

  // Divider operand preparation.
  logic signed [hre_pkg::NACC_W-1:0] nsel;
  logic [hre_pkg::MAG_W-1:0] amag;
  logic [hre_pkg::MAG_W-1:0] bmag;
  logic [hre_pkg::REM_W-1:0] numer;
  logic [hre_pkg::DIV_W-1:0] dsat;
  logic                      dge;
  logic [hre_pkg::REM_W-1:0] rem_sub;

  always_comb begin
    nsel  = coord ? nacc[1] : nacc[0];
    amag  = nsel[hre_pkg::NACC_W-1] ? hre_pkg::MAG_W'(-nsel) : hre_pkg::MAG_W'(nsel);
    bmag  = nacc[2][hre_pkg::NACC_W-1] ? hre_pkg::MAG_W'(-nacc[2])
                                       : hre_pkg::MAG_W'(nacc[2]);
    numer = hre_pkg::REM_W'(amag) << hre_pkg::FRAC;
    dsat  = hre_pkg::DIV_W'(bmag) << 22;
    dge   = hre_pkg::DIV_W'(rem) >= dvs;
    rem_sub = rem - hre_pkg::REM_W'(dvs);
  end

  // Signed distance from the reference coordinate to the projected one.
  logic [hre_pkg::QUO_W-1:0] qcap;
  logic signed [23:0] mapped;
  logic signed [23:0] diff;
  logic [hre_pkg::COORD_W-1:0] ref_c;
  always_comb begin
    qcap   = (quo > hre_pkg::PX_LIMIT) ? hre_pkg::PX_LIMIT : quo;
    mapped = neg ? -$signed({2'b0, qcap}) : $signed({2'b0, qcap});
    ref_c  = coord ? item.ref_y : item.ref_x;
    diff   = $signed({4'b0, ref_c}) - mapped;
  end

  logic [hre_pkg::SQ_W-1:0] stry;
  assign stry = sres + sbit;

  assign in_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      error_sum  <= '0;
      pair_count <= '0;
      for (int i = 0; i < hre_pkg::NREGS; i++) begin
        hreg[i] <= hre_pkg::H_RESET[i];
      end
    end else begin
      if (state == EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        hreg[cfg_index] <= cfg_data;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            item    <= in_data;
            pi      <= '0;
            row     <= '0;
            col     <= '0;
            nacc[0] <= '0;
            nacc[1] <= '0;
            nacc[2] <= hre_pkg::NACC_W'(1) << (16 + hre_pkg::FRAC);
            if (in_data.has_match && pair_count < hre_pkg::COUNT_W'(hre_pkg::MAX_PTS)) begin
              state <= MUL_LO;
            end else if (in_data.last) begin
              state <= MEAN_LOAD;
            end
          end
        end
        MUL_LO: begin
          plo   <= mul_p;
          state <= MUL_HI;
        end
        MUL_HI: begin
          nacc[row] <= nacc[row] + prod_q;
          pi        <= pi + 1'b1;
          if (col == 2'd2 || (row == 2'd2 && col == 2'd1)) begin
            row <= row + 1'b1;
            col <= '0;
          end else begin
            col <= col + 1'b1;
          end
          state <= (pi == hre_pkg::IDX_W'(hre_pkg::NREGS - 1)) ? CHECK_W : MUL_LO;
        end
        CHECK_W: begin
          coord     <= 1'b0;
          mean_mode <= 1'b0;
          if (nacc[2] == '0) begin
            pair_dist <= hre_pkg::DIST_MAX;
            state     <= ACCUM;
          end else begin
            state <= DIV_LOAD;
          end
        end
        DIV_LOAD: begin
          neg <= nsel[hre_pkg::NACC_W-1] != nacc[2][hre_pkg::NACC_W-1];
          rem <= numer;
          if (hre_pkg::DIV_W'(numer) >= dsat) begin
            // The quotient is past the cap, so no division steps run.
            dvs <= '0;
            quo <= hre_pkg::PX_LIMIT;
            k   <= '0;
          end else begin
            dvs <= hre_pkg::DIV_W'(bmag) << 21;
            quo <= '0;
            k   <= hre_pkg::STEP_W'(21);
          end
          state <= DIV_STEP;
        end
        DIV_STEP: begin
          if (dvs != '0 || k != '0) begin
            if (dge) begin
              rem <= rem_sub;
            end
            quo <= {quo[hre_pkg::QUO_W-2:0], dge};
            dvs <= dvs >> 1;
            k   <= k - 1'b1;
          end
          if (k == '0) begin
            if (mean_mode) begin
              state <= EMIT;
            end else begin
              // Finish this coordinate with the final quotient bit in place.
              state <= SQ_X;
            end
          end
        end
        SQ_X: begin
          // Entered once per coordinate from the divider; square only after y.
          if (!coord) begin
            dxm   <= diff[23] ? hre_pkg::DIFF_W'(-diff) : hre_pkg::DIFF_W'(diff);
            coord <= 1'b1;
            state <= DIV_LOAD;
          end else begin
            dym   <= diff[23] ? hre_pkg::DIFF_W'(-diff) : hre_pkg::DIFF_W'(diff);
            state <= SQ_Y;
          end
        end
        SQ_Y: begin
          ssum  <= hre_pkg::SQ_W'(mul_p);
          coord <= 1'b0;
          state <= SQRT;
          sres  <= '0;
          sbit  <= hre_pkg::SQ_W'(1) << 44;
        end
        SQRT: begin
          if (coord == 1'b0) begin
            // Add the x square on the first pass.
            ssum  <= ssum + hre_pkg::SQ_W'(mul_p);
            coord <= 1'b1;
          end else if (sbit != '0) begin
            if (ssum >= stry) begin
              ssum <= ssum - stry;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end else begin
            pair_dist <= (sres > hre_pkg::SQ_W'(hre_pkg::DIST_MAX)) ? hre_pkg::DIST_MAX
                                                                     : sres[hre_pkg::COORD_W-1:0];
            state     <= ACCUM;
          end
        end
        ACCUM: begin
          error_sum  <= error_sum + hre_pkg::SUM_W'(pair_dist);
          pair_count <= pair_count + 1'b1;
          state      <= item.last ? MEAN_LOAD : IDLE;
        end
        MEAN_LOAD: begin
          mean_mode <= 1'b1;
          rem       <= hre_pkg::REM_W'(error_sum);
          dvs       <= hre_pkg::DIV_W'(pair_count) << 19;
          quo       <= '0;
          k         <= hre_pkg::STEP_W'(19);
          state     <= (pair_count == '0) ? EMIT : DIV_STEP;
        end
        EMIT: begin
          if (!out_valid || !out_stall) begin
            if (pair_count == '0) begin
              out_data <= '{mean_error: '0, match_count: '0, no_match: 1'b1};
            end else begin
              out_data <= '{mean_error: quo[hre_pkg::COORD_W-1:0],
                            match_count: pair_count, no_match: 1'b0};
            end
            error_sum  <= '0;
            pair_count <= '0;
            mean_mode  <= 1'b0;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* verif/homography_reprojection_error_test.sv */
module homography_reprojection_error_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [hre_pkg::IDX_W-1:0] {
    H11 = 3'd0, H12 = 3'd1, H13 = 3'd2, H21 = 3'd3,
    H22 = 3'd4, H23 = 3'd5, H31 = 3'd6, H32 = 3'd7
  } coef_idx_t;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int IN_BITS = $bits(hre_pkg::in_item_t);
  localparam logic signed [hre_pkg::COEF_W-1:0] ONE_Q = 48'sh0001_0000_0000;
  localparam logic signed [hre_pkg::COEF_W-1:0] COEF_MAX = {1'b0, {(hre_pkg::COEF_W-1){1'b1}}};
  localparam logic signed [hre_pkg::COEF_W-1:0] COEF_MIN = {1'b1, {(hre_pkg::COEF_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  hre_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hre_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [hre_pkg::IDX_W-1:0] cfg_index = '0;
  logic [hre_pkg::COEF_W-1:0] cfg_data = '0;

  // Shadow of the block: coefficients, running sum and pair count.
  logic signed [hre_pkg::COEF_W-1:0] coef [hre_pkg::NREGS];
  logic [hre_pkg::SUM_W-1:0] dist_sum;
  logic [hre_pkg::COUNT_W-1:0] pairs_seen;
  hre_pkg::out_item_t frame_results [$];

  longint cycles = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit quiet = 1'b0;

  homography_reprojection_error dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               frame_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [127:0] scaled_product(
      logic signed [hre_pkg::COEF_W-1:0] h, logic [20:0] v);
    logic signed [127:0] hh;
    logic signed [127:0] vv;
    hh = h;
    vv = {107'd0, v};
    return (hh * vv) >>> 16;
  endfunction

  function automatic logic signed [127:0] projected(logic signed [127:0] n,
                                                    logic signed [127:0] w);
    logic neg;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] q;
    neg = (n < 0) != (w < 0);
    a = (n < 0) ? -n : n;
    b = (w < 0) ? -w : w;
    if (a / b > (128'd1 << (21 - hre_pkg::FRAC))) q = 128'd1 << 21;
    else begin
      q = (a << hre_pkg::FRAC) / b;
      if (q > (128'd1 << 21)) q = 128'd1 << 21;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [hre_pkg::COORD_W-1:0] pair_error(hre_pkg::in_item_t it);
    logic signed [127:0] nx, ny, nw, dx, dy;
    logic [20:0] one;
    logic [63:0] d;
    one = 21'd1 << hre_pkg::FRAC;
    nx = scaled_product(coef[H11], {1'b0, it.cur_x})
       + scaled_product(coef[H12], {1'b0, it.cur_y})
       + scaled_product(coef[H13], one);
    ny = scaled_product(coef[H21], {1'b0, it.cur_x})
       + scaled_product(coef[H22], {1'b0, it.cur_y})
       + scaled_product(coef[H23], one);
    nw = scaled_product(coef[H31], {1'b0, it.cur_x})
       + scaled_product(coef[H32], {1'b0, it.cur_y})
       + (128'sd1 <<< (16 + hre_pkg::FRAC));
    if (nw == 0) return hre_pkg::DIST_MAX;
    dx = $signed({108'd0, it.ref_x}) - projected(nx, nw);
    dy = $signed({108'd0, it.ref_y}) - projected(ny, nw);
    d = int_sqrt(64'(dx * dx) + 64'(dy * dy));
    return (d > hre_pkg::DIST_MAX) ? hre_pkg::DIST_MAX : d[hre_pkg::COORD_W-1:0];
  endfunction

  function automatic void accumulate_pair(hre_pkg::in_item_t it);
    hre_pkg::out_item_t r;
    if (it.has_match && pairs_seen < hre_pkg::MAX_PTS) begin
      dist_sum = dist_sum + hre_pkg::SUM_W'(pair_error(it));
      pairs_seen = pairs_seen + 1'b1;
    end
    if (it.last) begin
      if (pairs_seen == 0) begin
        r = '{mean_error: '0, match_count: '0, no_match: 1'b1};
      end else begin
        r.mean_error = hre_pkg::COORD_W'(dist_sum / pairs_seen);
        r.match_count = pairs_seen;
        r.no_match = 1'b0;
      end
      frame_results.push_back(r);
      dist_sum = '0;
      pairs_seen = '0;
    end
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", field, cycles, got, want);
    errors++;
  endtask

  // The result side: random stall before each result, then check it.
  initial begin
    int w;
    hre_pkg::out_item_t want;
    forever begin
      w = quiet ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        @(negedge clk) out_stall = 1'b1;
        repeat (w - 1) @(negedge clk);
        @(negedge clk) out_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      results_seen++;
      if (frame_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = frame_results.pop_front();
        if (out_data.mean_error !== want.mean_error)
          report_mismatch("mean_error", out_data.mean_error, want.mean_error);
        if (out_data.match_count !== want.match_count)
          report_mismatch("match_count", out_data.match_count, want.match_count);
        if (out_data.no_match !== want.no_match)
          report_mismatch("no_match", out_data.no_match, want.no_match);
      end
    end
  end

  // Valid stays high after an accept; the next call lowers it when it draws a gap, as does drain_block.
  task automatic send_pair(hre_pkg::in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    accumulate_pair(it);
    items_sent++;
  endtask

  task automatic drain_block();
    @(negedge clk) in_valid = 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(coef_idx_t idx, logic signed [hre_pkg::COEF_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    coef[idx] = val;
    @(negedge clk) cfg_we = 1'b0;
  endtask

  task automatic load_homography(logic signed [hre_pkg::COEF_W-1:0] h [hre_pkg::NREGS]);
    drain_block();
    for (int i = 0; i < hre_pkg::NREGS; i++) write_coef(coef_idx_t'(i), h[i]);
  endtask

  function automatic hre_pkg::in_item_t make_pair(
      logic [hre_pkg::COORD_W-1:0] cx, logic [hre_pkg::COORD_W-1:0] cy,
      logic [hre_pkg::COORD_W-1:0] rx, logic [hre_pkg::COORD_W-1:0] ry,
      logic m, logic l);
    hre_pkg::in_item_t it;
    it.cur_x = cx;
    it.cur_y = cy;
    it.ref_x = rx;
    it.ref_y = ry;
    it.has_match = m;
    it.last = l;
    return it;
  endfunction

  function automatic logic signed [hre_pkg::COEF_W-1:0] rand_coef(int kind);
    logic signed [hre_pkg::COEF_W-1:0] v;
    v = hre_pkg::COEF_W'({$urandom(), $urandom()});
    case (kind)
      0: v = v >>> 20;
      1: v = v >>> 8;
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic signed [hre_pkg::COEF_W-1:0] h [hre_pkg::NREGS];
    send_pair(make_pair('0, '0, '1, '1, 1'b1, 1'b0));
    send_pair(make_pair('1, '1, '0, '0, 1'b1, 1'b0));
    send_pair(make_pair('1, '0, '1, '0, 1'b0, 1'b0));
    send_pair(make_pair(20'd1000, 20'd2000, 20'd1003, 20'd2004, 1'b1, 1'b1));
    // A frame with no matched pair reports zero and the no-match flag.
    send_pair(make_pair('1, '1, '0, '0, 1'b0, 1'b0));
    send_pair(make_pair('0, '0, '1, '1, 1'b0, 1'b1));
    send_pair(make_pair(20'd500, 20'd500, 20'd500, 20'd500, 1'b1, 1'b1));
    // Projective term of zero: w = -1.0 * x + 1.0 vanishes at x = 1.0.
    h = '{ONE_Q, '0, '0, '0, ONE_Q, '0, -ONE_Q, '0};
    load_homography(h);
    send_pair(make_pair(20'd256, 20'd77, 20'd10, 20'd10, 1'b1, 1'b0));
    send_pair(make_pair(20'd100, 20'd77, 20'd10, 20'd10, 1'b1, 1'b1));
    // A huge scale throws the mapped point far off, saturating the distance.
    h = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, '0, '0};
    load_homography(h);
    send_pair(make_pair('1, '1, '0, '1, 1'b1, 1'b0));
    send_pair(make_pair(20'd1, 20'd0, '1, '0, 1'b1, 1'b1));
    h = '{COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
    load_homography(h);
    send_pair(make_pair('1, 20'd3, 20'd12345, '1, 1'b1, 1'b0));
    send_pair(make_pair(20'd7, '1, '1, 20'd9, 1'b1, 1'b1));
  endtask

  task automatic test_random_frames();
    logic signed [hre_pkg::COEF_W-1:0] h [hre_pkg::NREGS];
    int kind, len, sent;
    hre_pkg::in_item_t it;
    sent = 0;
    for (int phase = 0; sent < 750; phase++) begin
      kind = phase % 5;
      for (int i = 0; i < hre_pkg::NREGS; i++) h[i] = rand_coef(kind == 4 ? 2 : kind % 2);
      if (kind < 2) begin
        // Near an affine map so that most distances stay well inside range.
        h[H11] = ONE_Q + (h[H11] >>> 6);
        h[H22] = ONE_Q + (h[H22] >>> 6);
        h[H31] = h[H31] >>> 16;
        h[H32] = h[H32] >>> 16;
      end else if (kind == 3) begin
        h = '{ONE_Q, '0, '0, '0, ONE_Q, '0, '0, '0};
      end
      load_homography(h);
      quiet = (phase % 4 == 3);
      for (int f = 0; f < 8; f++) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          it = IN_BITS'({$urandom(), $urandom(), $urandom()});
          if ($urandom_range(0, 1)) begin
            it.cur_x = hre_pkg::COORD_W'($urandom_range(0, 8191));
            it.cur_y = hre_pkg::COORD_W'($urandom_range(0, 8191));
            it.ref_x = it.cur_x + hre_pkg::COORD_W'($urandom_range(0, 255));
            it.ref_y = it.cur_y + hre_pkg::COORD_W'($urandom_range(0, 255));
          end
          it.has_match = ($urandom_range(0, 9) < 8);
          it.last = (k == len - 1);
          send_pair(it);
          sent++;
        end
        // Once per phase, hold the sender until every result is back.
        if (f == 4) begin
          @(negedge clk) in_valid = 1'b0;
          while (frame_results.size() != 0) @(posedge clk);
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < hre_pkg::NREGS; i++) coef[i] = hre_pkg::H_RESET[i];
    dist_sum = '0;
    pairs_seen = '0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    test_directed();
    test_random_frames();
    drain_block();
    $display("sent %0d keypoint items, checked %0d frame results", items_sent, results_seen);
    $display("covered extremes, zero projective term, saturation, random maps and stalls");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/hre_pkg.sv
src/homography_reprojection_error.sv
verif/homography_reprojection_error_test.sv
